>>> src/ptp_pkg.sv
package ptp_pkg;

   localparam int COORD_W = 8;
   localparam int REP_W   = 7;
   localparam int LEVEL_W = 8;
   localparam int SINE_W  = 16;

   // coordinate times repeat count
   localparam int PROD_W = COORD_W + REP_W;

   // reciprocal for the reduction modulo the texture size (size 16 and up)
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 21;
   localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

   // level arithmetic: sx + sy + 65536 + 256, then drop nine bits
   localparam int SUM_W   = 19;
   localparam int LVL_SHIFT = 9;
   localparam logic [SUM_W-1:0] LVL_BIAS = SUM_W'(65792);
   localparam logic [LEVEL_W:0] LVL_MAX  = (LEVEL_W+1)'(255);

   localparam logic [REP_W-1:0] REP_MIN = REP_W'(1);
   localparam logic [REP_W-1:0] REP_MAX = REP_W'(100);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_REPEATS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_REPEATS = CSR_IDX_W'(1);

   localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // stage load enables handed to each wave unit
   typedef struct packed {
      logic load_prod;
      logic load_quot;
      logic load_rem;
      logic load_sine;
   } wave_ctl_type;

endpackage

>>> src/ptp_wave.sv
module ptp_wave
   import ptp_pkg::*;
#(
   parameter int N_ENTRIES = 256
) (
   input  logic                     clock,
   input  wave_ctl_type             ctl,
   input  logic [COORD_W-1:0]       coord,
   input  logic [REP_W-1:0]         repeats,
   output logic signed [SINE_W-1:0] sine
);

   localparam int IDX_W = $clog2(N_ENTRIES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / N_ENTRIES);
   localparam logic [PROD_W-1:0]  N_PROD = PROD_W'(N_ENTRIES);
   localparam logic [IDX_W:0]     N_REM  = (IDX_W+1)'(N_ENTRIES);

   typedef logic signed [SINE_W-1:0] rom_type [N_ENTRIES];

   // sin(2*pi*i/N) in Q1.15 through the Q30 nested series
   function automatic rom_type build_rom();
      rom_type     tbl;
      logic [63:0] q, quad, r, t30, x, x2, p, s, m;
      for (int i = 0; i < N_ENTRIES; i++) begin
         q    = 64'(i) * 64'd4;
         quad = (q / N_ENTRIES) & 64'd3;
         r    = q % N_ENTRIES;
         if (quad[0]) begin
            t30 = ((64'(N_ENTRIES) - r) << 30) / N_ENTRIES;
         end else begin
            t30 = (r << 30) / N_ENTRIES;
         end
         x  = (t30 * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         p  = Q30_ONE - x2 / 110;
         p  = Q30_ONE - ((x2 * p) >> 30) / 72;
         p  = Q30_ONE - ((x2 * p) >> 30) / 42;
         p  = Q30_ONE - ((x2 * p) >> 30) / 20;
         p  = Q30_ONE - ((x2 * p) >> 30) / 6;
         s  = (x * p) >> 30;
         m  = (s + 64'd16384) >> 15;
         if (m > 64'd32767) begin
            m = 64'd32767;
         end
         if (quad[1]) begin
            tbl[i] = -$signed(SINE_W'(m));
         end else begin
            tbl[i] = $signed(SINE_W'(m));
         end
      end
      return tbl;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [PROD_W-1:0]         prod_ff;
   logic [PROD_W-1:0]         prod_q_ff;
   logic [QUOT_W-1:0]         quot_ff;
   logic [PROD_W+RECIP_W-1:0] recip_prod;
   logic [PROD_W-1:0]         rem_full;
   logic [IDX_W:0]            rem_ff;
   logic [IDX_W-1:0]          rom_addr;
   logic signed [SINE_W-1:0]  sine_ff;

   // estimate of prod / N, low by at most one
   assign recip_prod = (PROD_W+RECIP_W)'(prod_ff) * (PROD_W+RECIP_W)'(RECIP);
   // remainder stays below 2N, so the low bits are exact
   assign rem_full   = prod_q_ff - PROD_W'(PROD_W'(quot_ff) * N_PROD);
   assign rom_addr   = (rem_ff >= N_REM) ? IDX_W'(rem_ff - N_REM) : IDX_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= PROD_W'(coord) * PROD_W'(repeats);
      end
      if (ctl.load_quot) begin
         prod_q_ff <= prod_ff;
         quot_ff   <= recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
      end
      if (ctl.load_rem) begin
         rem_ff <= rem_full[IDX_W:0];
      end
      if (ctl.load_sine) begin
         sine_ff <= SINE_ROM[rom_addr];
      end
   end

   assign sine = sine_ff;

endmodule

>>> src/plasma_texture_pixel.sv
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata: x_coord[7:0], y_coord[15:8]
// rsp      out        rsp_tvalid/tready    tdata: level[7:0]
// csr      in         csr_valid/ready      csr_index, csr_data (repeat counts)
//
// Five register stages: product, reciprocal quotient, remainder, sine table
// read, level. A transfer enters in every cycle unless the full pipe stalls.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it loads, so bubbles close up under a stalled result.
// Synchronous active-high reset clears the valid bits and sets both repeat
// counts to one. The sine tables are constant and need no clearing.
module plasma_texture_pixel
   import ptp_pkg::*;
#(
   parameter int WIDTH_PIXELS  = 256,
   parameter int HEIGHT_PIXELS = 256
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // x_coord[7:0], y_coord[15:8]

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [LEVEL_W-1:0]   rsp_tdata,   // level[7:0]

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data     // repeat count in [6:0]
);

   logic [REP_W-1:0] x_repeats_ff, x_repeats_in;
   logic [REP_W-1:0] y_repeats_ff, y_repeats_in;
   logic [REP_W-1:0] csr_sat;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic load1, load2, load3, load4, load5;
   wave_ctl_type ctl;

   logic signed [SINE_W-1:0] sine_x, sine_y;
   logic [SUM_W-1:0]         sum;
   logic [LEVEL_W:0]         level_raw;
   logic [LEVEL_W-1:0]       level_ff, level_in;

   // ---------------------------------------------------------------------
   // Configuration: always ready, saturate the count into 1..100
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_data[REP_W-1:0] < REP_MIN) begin
         csr_sat = REP_MIN;
      end else if (csr_data[REP_W-1:0] > REP_MAX) begin
         csr_sat = REP_MAX;
      end else begin
         csr_sat = csr_data[REP_W-1:0];
      end
   end

   always_comb begin
      x_repeats_in = x_repeats_ff;
      y_repeats_in = y_repeats_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_REPEATS: x_repeats_in = csr_sat;
            CSR_Y_REPEATS: y_repeats_in = csr_sat;
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_repeats_ff <= REP_MIN;
         y_repeats_ff <= REP_MIN;
      end else begin
         x_repeats_ff <= x_repeats_in;
         y_repeats_ff <= y_repeats_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: advance a stage when empty or its successor loads
   // ---------------------------------------------------------------------
   assign load5 = !v5_ff || rsp_tready;
   assign load4 = !v4_ff || load5;
   assign load3 = !v3_ff || load4;
   assign load2 = !v2_ff || load3;
   assign load1 = !v1_ff || load2;

   assign req_tready = load1;

   assign ctl.load_prod = load1;
   assign ctl.load_quot = load2;
   assign ctl.load_rem  = load3;
   assign ctl.load_sine = load4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= req_tvalid;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
         if (load4) v4_ff <= v3_ff;
         if (load5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // One wave per axis: reduce the scaled coordinate, look up the sine
   // ---------------------------------------------------------------------
   ptp_wave #(
      .N_ENTRIES (WIDTH_PIXELS)
   ) u_wave_x (
      .clock   (clock),
      .ctl     (ctl),
      .coord   (req_tdata[COORD_W-1:0]),
      .repeats (x_repeats_ff),
      .sine    (sine_x)
   );

   ptp_wave #(
      .N_ENTRIES (HEIGHT_PIXELS)
   ) u_wave_y (
      .clock   (clock),
      .ctl     (ctl),
      .coord   (req_tdata[2*COORD_W-1:COORD_W]),
      .repeats (y_repeats_ff),
      .sine    (sine_y)
   );

   // ---------------------------------------------------------------------
   // Level: average the two waves around mid grey, round half up, clamp
   // ---------------------------------------------------------------------
   assign sum       = SUM_W'(sine_x) + SUM_W'(sine_y) + LVL_BIAS;
   assign level_raw = sum[LVL_SHIFT+LEVEL_W:LVL_SHIFT];
   assign level_in  = (level_raw > LVL_MAX) ? LVL_MAX[LEVEL_W-1:0]
                                            : level_raw[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (load5) begin
         level_ff <= level_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = level_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_x_rep_range : assert property (@(posedge clock) disable iff (reset)
      (x_repeats_ff >= REP_MIN) && (x_repeats_ff <= REP_MAX))
      else $error("x repeat count out of range");

   a_y_rep_range : assert property (@(posedge clock) disable iff (reset)
      (y_repeats_ff >= REP_MIN) && (y_repeats_ff <= REP_MAX))
      else $error("y repeat count out of range");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && v4_ff && v3_ff && v2_ff && v1_ff) |-> !req_tready)
      else $error("input taken while every stage is full and stalled");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

>>> tb/tb_top.sv
module tb_top
   import ptp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEX_W = 256;
   localparam int TEX_H = 256;

   // register indexes past the two repeat counts: writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   localparam int ITEMS_PER_PHASE = 70;
   localparam int DRAIN_CYCLES    = 12;

   // -------------------------------------------------------------------------
   // Expected plasma levels: a private copy of the repeat counts, the level
   // arithmetic, and the queue of levels still owed by the block.
   // -------------------------------------------------------------------------
   class expected_levels;
      logic [LEVEL_W-1:0] levels_due[$];
      logic [REP_W-1:0]   x_rep = REP_MIN;
      logic [REP_W-1:0]   y_rep = REP_MIN;
      int                 errors  = 0;
      int                 checked = 0;

      static function logic [REP_W-1:0] saturate_rep(logic [15:0] data);
         logic [REP_W-1:0] v;
         v = data[REP_W-1:0];
         if (v < REP_MIN)
            return REP_MIN;
         if (v > REP_MAX)
            return REP_MAX;
         return v;
      endfunction

      // sin(2*pi*idx/n) in Q1.15 via a quarter-wave Q30 series
      static function int wave_q15(int unsigned idx, int unsigned n);
         longint unsigned q, quad, r, t30, x, x2, p, s, m;
         q    = longint'(idx) * 4;
         quad = (q / n) & 3;
         r    = q % n;
         if (quad[0])
            t30 = ((longint'(n) - r) << 30) / n;
         else
            t30 = (r << 30) / n;
         x  = (t30 * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         p  = Q30_ONE - x2 / 110;
         p  = Q30_ONE - ((x2 * p) >> 30) / 72;
         p  = Q30_ONE - ((x2 * p) >> 30) / 42;
         p  = Q30_ONE - ((x2 * p) >> 30) / 20;
         p  = Q30_ONE - ((x2 * p) >> 30) / 6;
         s  = (x * p) >> 30;
         m  = (s + 16384) >> 15;
         if (m > 32767)
            m = 32767;
         return (quad >= 2) ? -int'(m) : int'(m);
      endfunction

      function logic [LEVEL_W-1:0] plasma_level(logic [7:0] xc, logic [7:0] yc);
         int unsigned px, py;
         int          sum, lvl;
         px  = (int'(xc) * int'(x_rep)) % TEX_W;
         py  = (int'(yc) * int'(y_rep)) % TEX_H;
         sum = wave_q15(px, TEX_W) + wave_q15(py, TEX_H) + int'(LVL_BIAS);
         lvl = sum >>> LVL_SHIFT;
         if (lvl > 255)
            lvl = 255;
         return LEVEL_W'(lvl);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
         case (idx)
            CSR_X_REPEATS: x_rep = saturate_rep(data);
            CSR_Y_REPEATS: y_rep = saturate_rep(data);
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [7:0] xc, logic [7:0] yc);
         levels_due.push_back(plasma_level(xc, yc));
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_level(logic [LEVEL_W-1:0] got);
         logic [LEVEL_W-1:0] want;
         checked++;
         if (levels_due.size() == 0) begin
            report_mismatch($sformatf("level %0d with no pixel outstanding", got));
         end else begin
            want = levels_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("level %0d, expected %0d", got, want));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // x_coord[7:0], y_coord[15:8]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [LEVEL_W-1:0]   rsp_tdata;         // level[7:0]
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]          csr_data   = '0;   // repeat count in [6:0]

   expected_levels levels = new();

   int burst_left    = 1;
   int reg_writes    = 0;
   int spare_writes  = 0;
   int settings_seen = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   plasma_texture_pixel #(
      .WIDTH_PIXELS (TEX_W),
      .HEIGHT_PIXELS(TEX_H)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample every handshake at the rising edge, before the block's
   // registers update. Register writes and pixels feed the predictor, each
   // result transfer is checked against the oldest expected level.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            levels.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            levels.note_pixel(req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready)
            levels.check_level(rsp_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver back-pressure: switch at random between free running, coin-toss,
   // sparse and very sparse acceptance.
   // -------------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks
   // -------------------------------------------------------------------------

   // Offer one pixel and hold it until taken. Keep tvalid high across a burst;
   // at the end of a burst drop it for a random gap, or sometimes not at all.
   task automatic send_pixel(input logic [7:0] xc, input logic [7:0] yc);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {yc, xc};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Write one register; leave csr_valid high unless this is the last write
   // of the group, so the strobe is never lowered and raised in one step.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_X_REPEATS || idx == CSR_Y_REPEATS)
         reg_writes++;
      else
         spare_writes++;
      if (last)
         csr_valid <= 1'b0;
   endtask

   // Stop offering pixels, wait for every owed level, then let the pipeline
   // settle so a register write can never overtake a pixel in flight.
   task automatic drain_pipe;
      req_tvalid <= 1'b0;
      while (levels.levels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_repeats(input logic [15:0] xv, input logic [15:0] yv, input bit spares);
      drain_pipe();
      csr_write(CSR_X_REPEATS, xv, 1'b0);
      if (spares) begin
         csr_write(CSR_SPARE_LO, 16'($urandom), 1'b0);
         csr_write(CSR_SPARE_HI, 16'($urandom), 1'b0);
      end
      csr_write(CSR_Y_REPEATS, yv, 1'b1);
      settings_seen++;
   endtask

   // Mostly uniform coordinates, with a share of the wave landmarks
   // (zero crossings, peaks, troughs) and the field extremes.
   task automatic random_pixels(input int count);
      logic [7:0] xc, yc;
      int         pick;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            xc = 8'($urandom);
            yc = 8'($urandom);
         end else if (pick < 8) begin
            xc = 8'($urandom_range(0, 3) * 64 + $urandom_range(0, 2) - 1);
            yc = 8'($urandom_range(0, 3) * 64 + $urandom_range(0, 2) - 1);
         end else begin
            xc = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            yc = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         send_pixel(xc, yc);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset repeat counts: one period across each axis. Hit both peaks
      // together (the level clamps), both troughs, the zero crossings and
      // the coordinate extremes.
      send_pixel(8'd0,   8'd0);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd64,  8'd64);
      send_pixel(8'd192, 8'd192);
      send_pixel(8'd64,  8'd192);
      send_pixel(8'd192, 8'd64);
      send_pixel(8'd128, 8'd128);
      send_pixel(8'd64,  8'd0);
      send_pixel(8'd0,   8'd64);
      send_pixel(8'd255, 8'd0);
      send_pixel(8'd0,   8'd255);
      send_pixel(8'd1,   8'd1);
      send_pixel(8'd127, 8'd129);
      send_pixel(8'd32,  8'd96);
      send_pixel(8'd160, 8'd224);
      send_pixel(8'hAA,  8'h55);
      send_pixel(8'h55,  8'hAA);
      random_pixels(ITEMS_PER_PHASE);

      // Top of the range: products wrap many times round the texture.
      set_repeats(16'd100, 16'd100, 1'b0);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd64,  8'd16);
      random_pixels(ITEMS_PER_PHASE);

      // Saturation: zero climbs to one, 127 falls to 100.
      set_repeats(16'd0, 16'd127, 1'b1);
      random_pixels(ITEMS_PER_PHASE);

      // Whole data word random; only the low seven bits count.
      set_repeats(16'($urandom), 16'($urandom), 1'b1);
      random_pixels(ITEMS_PER_PHASE);

      // Opposite extremes on the two axes.
      set_repeats(16'd1, 16'd100, 1'b0);
      random_pixels(ITEMS_PER_PHASE);

      set_repeats(16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)), 1'b1);
      random_pixels(ITEMS_PER_PHASE);

      // Upper data bits set: all ones saturates, 0x8001 leaves one.
      set_repeats(16'hFFFF, 16'h8001, 1'b0);
      random_pixels(ITEMS_PER_PHASE);

      drain_pipe();

      $display("Checked %0d plasma levels over %0d repeat-count settings.",
               levels.checked, settings_seen + 1);
      $display("Register writes: %0d to the repeat counts, %0d to unused indexes.",
               reg_writes, spare_writes);
      if (levels.errors == 0 && levels.levels_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
src/ptp_pkg.sv
src/ptp_wave.sv
src/plasma_texture_pixel.sv
tb/tb_top.sv
